// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Clock is clk_i, reset is rst_ni (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rled_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rled_pkg;

  localparam int unsigned RUN_W      = 31;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_BIT = 2;

  localparam logic [7:0]       ESCAPE_RESET  = 8'd92;
  localparam logic [RUN_W-1:0] MAX_RUN_RESET = 31'h7FFF_FFFF;
  localparam logic [7:0]       DIGIT_ZERO    = 8'h30;
  localparam logic [7:0]       DIGIT_NINE    = 8'h39;

  // result queue
  localparam int unsigned Q_DEPTH = 3;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_REP  = 3'd2,
    MODE_DIG  = 3'd3,
    MODE_DROP = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_RUN = 2'd0,
    KIND_ERR = 2'd1,
    KIND_END = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_ESC_END = 2'd0,
    ERR_NO_NUM  = 2'd1,
    ERR_TOO_BIG = 2'd2
  } err_e;

  typedef enum logic {
    REG_ESCAPE_CHAR = 1'b0,
    REG_MAX_RUN     = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       value;
    logic [RUN_W-1:0] run_count;
    err_e             error_code;
    logic             stream_done;
    logic             item_done;
  } res_t;

  typedef struct packed {
    logic [7:0]       escape_char;
    logic [RUN_W-1:0] max_run;
  } cfg_t;

  // results handed from the decoder to the queue in one cycle
  typedef struct packed {
    logic [Q_CNT_W-1:0] n;
    res_t               r0;
    res_t               r1;
  } push_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] free;
  } q_stat_t;

  function automatic res_t run_rec(logic [7:0] value, logic [RUN_W-1:0] cnt, logic sd);
    res_t r;
    r = '0;
    r.kind        = KIND_RUN;
    r.value       = value;
    r.run_count   = cnt;
    r.error_code  = ERR_ESC_END;
    r.stream_done = sd;
    return r;
  endfunction

  function automatic res_t err_rec(err_e code, logic sd);
    res_t r;
    r = '0;
    r.kind        = KIND_ERR;
    r.error_code  = code;
    r.stream_done = sd;
    return r;
  endfunction

  function automatic res_t end_rec();
    res_t r;
    r = '0;
    r.kind        = KIND_END;
    r.error_code  = ERR_ESC_END;
    r.stream_done = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rled_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rled_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rled_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rled_cfg
  import rled_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  logic [7:0]       esc_q;
  logic [7:0]       esc_d;
  logic [RUN_W-1:0] max_run_q;
  logic [RUN_W-1:0] max_run_d;
  logic             wr_en;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[REG_IDX_BIT]);

  always_comb begin
    esc_d     = esc_q;
    max_run_d = max_run_q;
    prdata    = '0;
    unique case (idx)
      REG_ESCAPE_CHAR: begin
        prdata = APB_DATA_W'(esc_q);
        if (wr_en) esc_d = pwdata[7:0];
      end
      REG_MAX_RUN: begin
        prdata = APB_DATA_W'(max_run_q);
        if (wr_en) max_run_d = pwdata[RUN_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q     <= ESCAPE_RESET;
      max_run_q <= MAX_RUN_RESET;
    end else begin
      esc_q     <= esc_d;
      max_run_q <= max_run_d;
    end
  end

  assign cfg_o.escape_char = esc_q;
  assign cfg_o.max_run     = max_run_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rled_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rled_decode
  import rled_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 31
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  rled_chan_if.sink    in_i,
  input  wire cfg_t    cfg_i,
  input  wire q_stat_t stat_i,
  output push_t        push_o
);

  // wide enough for acc*10+9 and for max_run
  localparam int unsigned W = ((COUNT_BITS > RUN_W) ? COUNT_BITS : RUN_W) + 4;

  logic                  item_vld_q;
  logic                  item_vld_d;
  in_item_t              item_q;
  mode_e                 mode_q;
  mode_e                 mode_d;
  logic [7:0]            rep_q;
  logic [7:0]            rep_d;
  logic [COUNT_BITS-1:0] acc_q;
  logic [COUNT_BITS-1:0] acc_d;

  logic                  accept;
  logic                  consume;
  logic [7:0]            b;
  logic                  eos;
  logic                  is_esc;
  logic                  digit;
  logic [W-1:0]          acc_ext;
  logic [W-1:0]          acc_next;
  logic [W-1:0]          mr_ext;
  logic [W-1:0]          mask_ext;
  logic [W-1:0]          limit;
  logic                  too_big;
  logic                  end_s;
  logic [Q_CNT_W-1:0]    n;
  res_t                  r0;
  res_t                  r1;

  assign b       = item_q.data_byte;
  assign eos     = item_q.end_of_stream;
  assign is_esc  = (b == cfg_i.escape_char);
  assign digit   = (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);

  // acc * 10 + digit, low nibble of an ASCII digit is its value
  assign acc_ext  = W'(acc_q);
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + W'(b[3:0]);
  assign mr_ext   = W'(cfg_i.max_run);
  assign mask_ext = (W'(1) << COUNT_BITS) - W'(1);
  assign limit    = (mr_ext > mask_ext) ? mask_ext : mr_ext;
  assign too_big  = (acc_next > limit);

  always_comb begin
    mode_d = mode_q;
    rep_d  = rep_q;
    acc_d  = acc_q;
    r0     = '0;
    r1     = '0;
    n      = '0;
    end_s  = 1'b0;
    unique case (mode_q)
      MODE_IDLE: begin
        if (is_esc) begin
          if (eos) begin
            r0    = err_rec(ERR_ESC_END, 1'b1);
            n     = Q_CNT_W'(1);
            end_s = 1'b1;
          end else begin
            mode_d = MODE_ESC;
          end
        end else begin
          r0    = run_rec(b, RUN_W'(1), eos);
          n     = Q_CNT_W'(1);
          end_s = eos;
        end
      end
      MODE_ESC: begin
        if (is_esc) begin
          r0     = run_rec(b, RUN_W'(1), eos);
          n      = Q_CNT_W'(1);
          mode_d = MODE_IDLE;
          end_s  = eos;
        end else begin
          rep_d = b;
          acc_d = '0;
          if (eos) begin
            r0    = err_rec(ERR_NO_NUM, 1'b1);
            n     = Q_CNT_W'(1);
            end_s = 1'b1;
          end else begin
            mode_d = MODE_REP;
          end
        end
      end
      MODE_REP, MODE_DIG: begin
        if (digit) begin
          // a digit wins even when it equals the escape byte
          acc_d  = acc_next[COUNT_BITS-1:0];
          mode_d = MODE_DIG;
          if (too_big) begin
            r0 = err_rec(ERR_TOO_BIG, eos);
            n  = Q_CNT_W'(1);
            if (eos) end_s = 1'b1;
            else mode_d = MODE_DROP;
          end else if (eos) begin
            r0    = run_rec(rep_q, RUN_W'(acc_next), 1'b1);
            n     = Q_CNT_W'(1);
            end_s = 1'b1;
          end
        end else if (mode_q == MODE_REP) begin
          r0 = err_rec(ERR_NO_NUM, eos);
          n  = Q_CNT_W'(1);
          if (eos) end_s = 1'b1;
          else mode_d = MODE_DROP;
        end else begin
          // flush the pending run, then treat this byte as if idle
          r0     = run_rec(rep_q, RUN_W'(acc_q), 1'b0);
          acc_d  = '0;
          mode_d = MODE_IDLE;
          if (is_esc) begin
            if (eos) begin
              r1    = err_rec(ERR_ESC_END, 1'b1);
              n     = Q_CNT_W'(2);
              end_s = 1'b1;
            end else begin
              n      = Q_CNT_W'(1);
              mode_d = MODE_ESC;
            end
          end else begin
            r1    = run_rec(b, RUN_W'(1), eos);
            n     = Q_CNT_W'(2);
            end_s = eos;
          end
        end
      end
      default: begin
        // dropping after an error, and any unused code
        if (eos) begin
          r0    = end_rec();
          n     = Q_CNT_W'(1);
          end_s = 1'b1;
        end else begin
          mode_d = MODE_DROP;
        end
      end
    endcase
    if (end_s) begin
      mode_d = MODE_IDLE;
      acc_d  = '0;
      rep_d  = '0;
    end
    if (n == Q_CNT_W'(1)) r0.item_done = 1'b1;
    if (n == Q_CNT_W'(2)) r1.item_done = 1'b1;
  end

  // free space is registered in the queue, so ready never waits on the sink
  assign consume    = item_vld_q && (n <= stat_i.free);
  assign in_i.ready = !item_vld_q || consume;
  assign accept     = in_i.valid && in_i.ready;
  assign item_vld_d = accept ? 1'b1 : (consume ? 1'b0 : item_vld_q);

  assign push_o.n  = consume ? n : '0;
  assign push_o.r0 = r0;
  assign push_o.r1 = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      mode_q     <= MODE_IDLE;
      rep_q      <= '0;
      acc_q      <= '0;
    end else begin
      item_vld_q <= item_vld_d;
      if (consume) begin
        mode_q <= mode_d;
        rep_q  <= rep_d;
        acc_q  <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_i.data;
  end

  `ASSERT_NEXT(eos_to_idle, consume && eos, mode_q == MODE_IDLE)
  `ASSERT_IMPL(eos_gives_result, consume && eos, n != '0)
  `ASSERT_IMPL(done_on_last, push_o.n == Q_CNT_W'(2), !push_o.r0.item_done && push_o.r1.item_done)

endmodule

`default_nettype wire

// ===== hw/rtl/rled_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rled_outq
  import rled_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire push_t   push_i,
  output q_stat_t      stat_o,
  rled_chan_if.source  out_o
);

  res_t               q_q [Q_DEPTH];
  res_t               q_d [Q_DEPTH];
  logic [Q_CNT_W-1:0] cnt_q;
  logic [Q_CNT_W-1:0] cnt_d;
  logic [Q_CNT_W-1:0] base;
  logic               pop;

  assign pop         = out_o.valid && out_o.ready;
  assign out_o.valid = (cnt_q != '0);
  assign out_o.data  = q_q[0];
  assign stat_o.free = Q_CNT_W'(Q_DEPTH) - cnt_q;

  // slot 0 is the head; pops shift down, pushes land behind the survivors
  always_comb begin
    base = cnt_q - Q_CNT_W'(pop);
    for (int i = 0; i < Q_DEPTH - 1; i++) begin
      q_d[i] = pop ? q_q[i+1] : q_q[i];
    end
    q_d[Q_DEPTH-1] = q_q[Q_DEPTH-1];
    for (int i = 0; i < Q_DEPTH; i++) begin
      if ((push_i.n != '0) && (Q_CNT_W'(i) == base)) q_d[i] = push_i.r0;
      if ((push_i.n == Q_CNT_W'(2)) && (Q_CNT_W'(i) == base + Q_CNT_W'(1))) begin
        q_d[i] = push_i.r1;
      end
    end
    cnt_d = base + push_i.n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  `ASSERT_IMPL(push_fits, push_i.n != '0, push_i.n <= stat_o.free)
  `ASSERT_IMPL(cnt_bound, 1'b1, cnt_q <= Q_CNT_W'(Q_DEPTH))

endmodule

`default_nettype wire

// ===== hw/rtl/escaped_rle_decoder_top.sv =====
// Escaped run-length decoder. One encoded byte enters per request on in_i, with
// end_of_stream on the last byte of a stream; run, error and end-marker records
// leave on out_o. Runs are not expanded: a plain byte or a doubled escape gives a
// record of count 1, and escape + byte + decimal digits gives one record with the
// decimal count (a count of zero is still sent). A run with digits leaves when the
// first non-digit arrives, together with that byte's own record if it gives one,
// or when the stream ends on a digit. Errors are escape at end, missing number
// and count above max_run or 2^COUNT_BITS-1; after an error record on any byte
// but the last, the stream is dropped up to its end, which then yields a bare end
// marker; the sink must discard all records of a stream that carried an error.
// Rate: one byte per cycle while the result queue has room. Each byte is decoded
// in the input register against the decode state, and its records enter a
// three-entry result queue whose head is the output register. A byte that ends a
// digit string can give two records and holds the input until both fit.
// escape_char (offset 0x0) and max_run (offset 0x4) sit on the APB port; the user
// must write them only while the decoder is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module escaped_rle_decoder_top
  import rled_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 31
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  rled_chan_if.sink                  in_i,
  rled_chan_if.source                out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t    cfg;
  push_t   push;
  q_stat_t stat;

  // register file
  rled_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register, decode state and record builder
  rled_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg),
    .stat_i (stat),
    .push_o (push)
  );

  // result queue, head drives the output channel
  rled_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .stat_o (stat),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ===== test/escaped_rle_decoder_checker.sv =====
`timescale 1ns / 1ps

module escaped_rle_decoder_checker
  import rled_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rled_chan_if                  in_mon_i,
  rled_chan_if                  out_mon_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    fail_count_o,
  output int                    pending_o
);

  // shadow registers
  logic [7:0]       esc_char;
  logic [RUN_W-1:0] run_limit;

  // decoder state
  mode_e       dec_mode;
  logic [7:0]  rep_byte;
  logic [63:0] count_sum;

  res_t expected_recs[$];
  res_t step_recs[$];

  function automatic res_t make_rec(kind_e k, logic [7:0] v, logic [RUN_W-1:0] c, err_e e,
                                    logic sd);
    res_t r;
    r.kind        = k;
    r.value       = v;
    r.run_count   = c;
    r.error_code  = e;
    r.stream_done = sd;
    r.item_done   = 1'b0;
    return r;
  endfunction

  task automatic close_stream();
    dec_mode  = MODE_IDLE;
    count_sum = '0;
    rep_byte  = '0;
  endtask

  task automatic raise_fault(err_e code, logic eos);
    step_recs.insert(step_recs.size(), make_rec(KIND_ERR, 8'd0, '0, code, eos));
    if (eos) close_stream();
    else dec_mode = MODE_DROP;
  endtask

  // byte in idle mode, also the byte that closes a digit string
  task automatic plain_byte(logic [7:0] b, logic eos);
    if (b == esc_char) begin
      if (eos) raise_fault(ERR_ESC_END, 1'b1);
      else dec_mode = MODE_ESC;
    end else begin
      step_recs.insert(step_recs.size(), make_rec(KIND_RUN, b, RUN_W'(1), ERR_ESC_END, eos));
      if (eos) close_stream();
    end
  endtask

  task automatic take_digit(logic [7:0] b, logic eos);
    count_sum = count_sum * 64'd10 + (64'(b) - 64'(DIGIT_ZERO));
    dec_mode  = MODE_DIG;
    if (count_sum > 64'(run_limit)) begin
      raise_fault(ERR_TOO_BIG, eos);
    end else if (eos) begin
      step_recs.insert(step_recs.size(),
                       make_rec(KIND_RUN, rep_byte, count_sum[RUN_W-1:0], ERR_ESC_END, 1'b1));
      close_stream();
    end
  endtask

  task automatic decode_byte(logic [7:0] b, logic eos);
    logic is_digit;
    is_digit = (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
    step_recs.delete();
    case (dec_mode)
      MODE_IDLE: plain_byte(b, eos);
      MODE_ESC: begin
        if (b == esc_char) begin
          step_recs.insert(step_recs.size(), make_rec(KIND_RUN, b, RUN_W'(1), ERR_ESC_END, eos));
          if (eos) close_stream();
          else dec_mode = MODE_IDLE;
        end else begin
          rep_byte  = b;
          count_sum = '0;
          if (eos) raise_fault(ERR_NO_NUM, 1'b1);
          else dec_mode = MODE_REP;
        end
      end
      MODE_REP: begin
        if (is_digit) take_digit(b, eos);
        else raise_fault(ERR_NO_NUM, eos);
      end
      MODE_DIG: begin
        if (is_digit) begin
          take_digit(b, eos);
        end else begin
          step_recs.insert(step_recs.size(),
                           make_rec(KIND_RUN, rep_byte, count_sum[RUN_W-1:0], ERR_ESC_END,
                                    1'b0));
          count_sum = '0;
          dec_mode  = MODE_IDLE;
          plain_byte(b, eos);
        end
      end
      default: begin
        if (eos) begin
          step_recs.insert(step_recs.size(), make_rec(KIND_END, 8'd0, '0, ERR_ESC_END, 1'b1));
          close_stream();
        end else begin
          dec_mode = MODE_DROP;
        end
      end
    endcase
    if (step_recs.size() > 0) step_recs[step_recs.size()-1].item_done = 1'b1;
    foreach (step_recs[i]) expected_recs.insert(expected_recs.size(), step_recs[i]);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      esc_char  = ESCAPE_RESET;
      run_limit = MAX_RUN_RESET;
      close_stream();
      expected_recs.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // results first: a record never leaves in the cycle its byte enters
      if (out_mon_i.valid && out_mon_i.ready) begin
        got = out_mon_i.data;
        if (expected_recs.size() == 0) begin
          $error("unexpected record: kind %0d value 0x%0h count %0d", got.kind, got.value,
                 got.run_count);
          fail_count_o++;
        end else begin
          want = expected_recs.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("value", want.value, got.value);
          check_field("run_count", want.run_count, got.run_count);
          check_field("error_code", want.error_code, got.error_code);
          check_field("stream_done", want.stream_done, got.stream_done);
          check_field("item_done", want.item_done, got.item_done);
        end
      end
      if (in_mon_i.valid && in_mon_i.ready)
        decode_byte(in_mon_i.data.data_byte, in_mon_i.data.end_of_stream);
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_e'(paddr[REG_IDX_BIT]) == REG_ESCAPE_CHAR) esc_char = pwdata[7:0];
        else run_limit = pwdata[RUN_W-1:0];
      end
      pending_o = expected_recs.size();
    end
  end

endmodule

// ===== test/escaped_rle_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module escaped_rle_decoder_top_tb;
  import rled_pkg::*;

  // Cycles without any accepted request, record or register access before the
  // run is declared hung. Worst legal quiet stretch is a long receiver stall
  // or the short pause before a register write, far below this.
  localparam int STALL_LIMIT = 2000;
  // Random items per register setting; 8 settings give at least 384 items.
  localparam int PHASE_ITEMS = 48;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;

  rled_chan_if #(.T(in_item_t)) in_ch ();
  rled_chan_if #(.T(res_t))     out_ch ();

  escaped_rle_decoder_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // The checker mirrors the register writes it sees on the APB port, predicts
  // every record from the accepted bytes and compares in order.
  escaped_rle_decoder_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stimulus-side copy of the register values, used to shape the streams.
  logic [7:0]       cur_esc;
  logic [RUN_W-1:0] cur_limit;
  logic [7:0]       enc_bytes[$];  // encoded stream being assembled
  int               burst_left;
  int               items_sent;
  int               stall_cycles;

  // Hang detection: any accepted request, record or register access counts as
  // progress.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: the ready pattern keeps redrawing its style at random from always
  // ready, coin flip, mostly stalled and a fixed periodic window.
  initial begin
    int cyc;
    int style;
    cyc          = 0;
    style        = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (cyc % 48 == 0) style = $urandom_range(0, 3);
      case (style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ((cyc % 9) < 4);
      endcase
      cyc++;
    end
  end

  // One request on in_ch. Valid stays high across a burst; when a burst runs
  // out, valid drops for a random gap and a fresh burst length is drawn. Some
  // bursts are long so that stretches of back-to-back bytes occur too.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= in_item_t'{data_byte: b, end_of_stream: eos};
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Send the assembled bytes; end_of_stream goes on the last one.
  task automatic send_stream();
    foreach (enc_bytes[i]) send_byte(enc_bytes[i], i == enc_bytes.size() - 1);
    enc_bytes.delete();
  endtask

  task automatic add_byte(input logic [7:0] b);
    enc_bytes.insert(enc_bytes.size(), b);
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_byte(s[i]);
  endtask

  // Decimal count, sometimes with leading zeros.
  task automatic add_number(input longint unsigned n);
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) add_byte(DIGIT_ZERO);
    add_text($sformatf("%0d", n));
  endtask

  function automatic logic [7:0] other_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == cur_esc);
    return b;
  endfunction

  // Count values: mostly small, some right at the max_run boundary, some far
  // beyond the counter width.
  task automatic add_count();
    longint unsigned n;
    case ($urandom_range(0, 5))
      0, 1: n = $urandom_range(0, 9);
      2: n = $urandom_range(10, 9999);
      3: begin
        n = longint'(cur_limit) + $urandom_range(0, 2);
        if (n > 0) n = n - 1;
      end
      4: n = {32'd0, $urandom} % (longint'(cur_limit) + 1);
      default: n = {$urandom, $urandom} % 64'd1000000000000;
    endcase
    add_number(n);
  endtask

  // Mostly well-formed streams of random codes; some noise streams and some
  // broken codes to reach the error and drop paths.
  task automatic build_stream();
    int         pick;
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        pick = $urandom_range(0, 2);
        if (pick == 0) b = cur_esc;
        else if (pick == 1) b = 8'($urandom_range(DIGIT_ZERO, DIGIT_NINE));
        else b = 8'($urandom);
        add_byte(b);
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(0, 9);
        if (pick <= 2) begin
          add_byte(other_byte());
        end else if (pick == 3) begin
          add_byte(cur_esc);
          add_byte(cur_esc);
        end else if (pick <= 7) begin
          add_byte(cur_esc);
          add_byte(other_byte());
          add_count();
        end else if (pick == 8) begin
          // repeat byte followed by no number
          add_byte(cur_esc);
          add_byte(other_byte());
          do b = 8'($urandom); while (b >= DIGIT_ZERO && b <= DIGIT_NINE);
          add_byte(b);
        end else begin
          add_byte(cur_esc);
        end
      end
    end
  endtask

  // One APB write: setup then access. psel is left high so that a second
  // write can follow directly; the caller closes the transfer.
  task automatic apb_write(input reg_idx_e idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << REG_IDX_BIT;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  // Registers change only with the decoder drained. Bytes that produce no
  // record may still sit in the pipeline, so the wait runs on past the last record.
  // Unused upper data bits carry random junk.
  task automatic set_config(input logic [7:0] esc, input logic [RUN_W-1:0] limit);
    logic [APB_DATA_W-1:0] w;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    w      = $urandom;
    w[7:0] = esc;
    apb_write(REG_ESCAPE_CHAR, w);
    w            = $urandom;
    w[RUN_W-1:0] = limit;
    apb_write(REG_MAX_RUN, w);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    cur_esc    = esc;
    cur_limit  = limit;
    burst_left = 0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [7:0]       esc;
    logic [RUN_W-1:0] limit;
    int               goal;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    cur_esc       = ESCAPE_RESET;
    cur_limit     = MAX_RUN_RESET;
    burst_left    = 0;
    items_sent    = 0;
    stall_cycles  = 0;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // --- directed, reset settings (escape is backslash) ---
    // literals incl. 0x00/0xFF, doubled escape, zero-count run followed by a
    // literal (two records from one byte), run ending on the stream end
    add_text("A");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("\\\\\\x0,\\y12");
    send_stream();
    // missing number mid-stream, dropped byte, then a bare end marker
    add_text("\\zqb");
    send_stream();
    // escape right at the stream end
    add_text("\\");
    send_stream();
    // stream ends on the repeat byte
    add_text("\\b");
    send_stream();

    // escape is itself a digit: inside a count it still counts as a digit
    set_config("7", RUN_W'(100));
    add_text("7e77y");
    send_stream();

    // max_run zero: count 0 passes, count 1 faults on the last byte
    set_config(ESCAPE_RESET, '0);
    add_text("\\d0\\d1");
    send_stream();

    // --- random, several register settings incl. the extremes ---
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin esc = ESCAPE_RESET; limit = RUN_W'($urandom_range(1, 50)); end
        1: begin esc = 8'h00;        limit = MAX_RUN_RESET;                 end
        2: begin esc = 8'hFF;        limit = RUN_W'(1);                     end
        3: begin esc = "5";          limit = RUN_W'(9);                     end
        4: begin esc = 8'($urandom); limit = '0;                            end
        5: begin esc = DIGIT_ZERO;   limit = RUN_W'(1000);                  end
        6: begin esc = 8'($urandom); limit = RUN_W'($urandom);              end
        default: begin esc = ESCAPE_RESET; limit = MAX_RUN_RESET;           end
      endcase
      set_config(esc, limit);
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        build_stream();
        send_stream();
      end
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rled_pkg.sv
hw/rtl/rled_chan_if.sv
hw/rtl/rled_cfg.sv
hw/rtl/rled_decode.sv
hw/rtl/rled_outq.sv
hw/rtl/escaped_rle_decoder_top.sv
test/escaped_rle_decoder_checker.sv
test/escaped_rle_decoder_top_tb.sv
